// File: src/voice_slot_allocator_oldest_steal_assert.svh
// assertion macros for the voice slot allocator checker
// depends on nothing; included by the checker file
`ifndef VOICE_SLOT_ALLOCATOR_OLDEST_STEAL_ASSERT_SVH
`define VOICE_SLOT_ALLOCATOR_OLDEST_STEAL_ASSERT_SVH

// same-cycle implication
`define VSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/vsa_pkg.sv
// shared types and constants of the voice slot allocator
// depends on nothing
`timescale 1ns / 1ps

package vsa_pkg;

    localparam int VSA_NUM_SLOTS_DEF = 8;

    localparam logic [1:0] REQ_ALLOC    = 2'd0;
    localparam logic [1:0] REQ_RELEASE  = 2'd1;
    localparam logic [1:0] REQ_STOP_ALL = 2'd2;

    typedef struct packed {
        logic [3:0] busy_count;
        logic       status;
        logic       stole_voice;
        logic [2:0] granted_slot;
    } vsa_result_t;

endpackage

// File: src/vsa_age_mem.sv
// age order list storage: one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps

module vsa_age_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 3
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign rd_data = rdata_reg;

endmodule

// File: src/vsa_ctrl.sv
// request sequencer: busy bits, list length, walk over the age list memory
// depends on vsa_pkg; drives vsa_age_mem
`timescale 1ns / 1ps

module vsa_ctrl
    import vsa_pkg::*;
#(
    parameter int NUM_SLOTS = VSA_NUM_SLOTS_DEF,
    parameter int SW        = $clog2(NUM_SLOTS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_valid,
    output logic          req_ready,
    input  logic [1:0]    req_type,
    input  logic [2:0]    req_slot,
    output logic          res_valid,
    input  logic          res_ready,
    output vsa_result_t   res,
    output logic          mem_we,
    output logic [SW-1:0] mem_waddr,
    output logic [SW-1:0] mem_wdata,
    output logic [SW-1:0] mem_raddr,
    input  logic [SW-1:0] mem_rdata
);

    localparam int CW   = $clog2(NUM_SLOTS + 1);
    localparam int CMPW = (SW > 3) ? SW : 3;
    localparam int LW   = (CW > 4) ? CW : 4;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_TAIL  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [NUM_SLOTS-1:0] busy_reg, busy_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [1:0]           type_reg, type_next;
    logic [2:0]           slot_reg, slot_next;
    logic [SW-1:0]        pos_reg, pos_next;
    logic                 steal_reg, steal_next;
    logic                 status_reg, status_next;
    logic [SW-1:0]        victim_reg, victim_next;
    logic [2:0]           out_slot_reg, out_slot_next;

    logic                 free_found;
    logic [SW-1:0]        free_idx;
    logic [SW-1:0]        alloc_slot;
    logic [CMPW-1:0]      idx_ext;
    logic [SW-1:0]        idx_sel;
    logic                 idx_busy;
    logic [CMPW-1:0]      alloc_ext;
    logic [CMPW-1:0]      rd_ext;
    logic                 rd_match;
    logic [CW:0]          len_ext;
    logic [CW:0]          pos1;
    logic [CW:0]          pos2;
    logic [CW-1:0]        len_dec;
    logic [LW-1:0]        len_wide;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    assign alloc_slot = free_found ? free_idx : '0;
    assign alloc_ext  = CMPW'(alloc_slot);
    assign idx_ext    = CMPW'(slot_reg);
    assign idx_sel    = idx_ext[SW-1:0];
    assign idx_busy   = (32'(slot_reg) < 32'(NUM_SLOTS)) && busy_reg[idx_sel];
    assign rd_ext     = CMPW'(mem_rdata);
    assign rd_match   = steal_reg || (rd_ext == idx_ext);
    assign len_ext    = {1'b0, len_reg};
    assign pos1       = (CW + 1)'(pos_reg) + (CW + 1)'(1);
    assign pos2       = (CW + 1)'(pos_reg) + (CW + 1)'(2);
    assign len_dec    = len_reg - CW'(1);
    assign len_wide   = LW'(len_reg);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    assign res.granted_slot = out_slot_reg;
    assign res.stole_voice  = steal_reg;
    assign res.status       = status_reg;
    assign res.busy_count   = len_wide[3:0];

    always_comb begin
        state_next    = state_reg;
        busy_next     = busy_reg;
        len_next      = len_reg;
        type_next     = type_reg;
        slot_next     = slot_reg;
        pos_next      = pos_reg;
        steal_next    = steal_reg;
        status_next   = status_reg;
        victim_next   = victim_reg;
        out_slot_next = out_slot_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = mem_rdata;
        mem_raddr     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    type_next  = req_type;
                    slot_next  = req_slot;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                steal_next    = 1'b0;
                status_next   = 1'b0;
                out_slot_next = '0;
                pos_next      = '0;
                case (type_reg)
                    REQ_ALLOC: begin
                        if (free_found || (len_reg == '0)) begin
                            mem_we               = 1'b1;
                            mem_waddr            = len_reg[SW-1:0];
                            mem_wdata            = alloc_slot;
                            busy_next[alloc_slot] = 1'b1;
                            len_next             = len_reg + CW'(1);
                            out_slot_next        = alloc_ext[2:0];
                            state_next           = ST_DONE;
                        end else begin
                            steal_next = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    REQ_RELEASE: begin
                        out_slot_next = slot_reg;
                        if (idx_busy) begin
                            state_next = ST_SCAN;
                        end else begin
                            status_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                    end
                    REQ_STOP_ALL: begin
                        busy_next  = '0;
                        len_next   = '0;
                        state_next = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                if (rd_match) begin
                    if (steal_reg) begin
                        victim_next   = mem_rdata;
                        out_slot_next = rd_ext[2:0];
                    end
                    if (pos1 < len_ext) begin
                        mem_raddr  = pos1[SW-1:0];
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = ST_TAIL;
                    end
                end else if (pos1 < len_ext) begin
                    mem_raddr = pos1[SW-1:0];
                    pos_next  = pos1[SW-1:0];
                end else begin
                    busy_next[idx_sel] = 1'b0;
                    state_next         = ST_DONE;
                end
            end
            ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = mem_rdata;
                pos_next  = pos1[SW-1:0];
                if (pos2 < len_ext) begin
                    mem_raddr = pos2[SW-1:0];
                end else begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (steal_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = len_dec[SW-1:0];
                    mem_wdata = victim_reg;
                end else begin
                    busy_next[idx_sel] = 1'b0;
                    len_next           = len_dec;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            busy_reg  <= '0;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg     <= type_next;
        slot_reg     <= slot_next;
        pos_reg      <= pos_next;
        steal_reg    <= steal_next;
        status_reg   <= status_next;
        victim_reg   <= victim_next;
        out_slot_reg <= out_slot_next;
    end

endmodule

// File: src/voice_slot_allocator_oldest_steal.sv
// voice slot allocator with oldest-voice stealing, one request word at a time
// allocate into a free slot, release of an idle slot, stop all and an unused request
//   type go straight from execute to the result; a steal or a busy release walks the list
// the next word is accepted only after the last result is handed on; the walk reads the
//   age list memory one entry per cycle; a held result does not block the next accept
// synchronous reset clears busy bits and list length; the list memory is not cleared
`timescale 1ns / 1ps

module voice_slot_allocator_oldest_steal
    import vsa_pkg::*;
#(
    parameter int NUM_SLOTS = VSA_NUM_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] slot_index
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] granted_slot, [3] stole_voice, [4] status,
                                   // [8:5] busy_count
);

    localparam int SW = $clog2(NUM_SLOTS);

    vsa_result_t   res;
    vsa_result_t   out_reg;
    logic          m_valid_reg;
    logic          res_valid;
    logic          res_ready;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic [SW-1:0] mem_raddr;
    logic [SW-1:0] mem_rdata;

    assign res_ready = !m_valid_reg || m_tready;

    vsa_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .SW        (SW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_type  (s_tuser),
        .req_slot  (s_tdata[2:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    vsa_age_mem #(
        .DEPTH (NUM_SLOTS),
        .WIDTH (SW)
    ) u_age_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_reg.busy_count, out_reg.status, out_reg.stole_voice,
                       out_reg.granted_slot};

endmodule

// File: src/vsa_checker.sv
// port-level checks of the voice slot allocator, bound to the top level
// depends on vsa_pkg and voice_slot_allocator_oldest_steal_assert.svh
`timescale 1ns / 1ps
`include "voice_slot_allocator_oldest_steal_assert.svh"

module vsa_checker
    import vsa_pkg::*;
#(
    parameter int NUM_SLOTS = VSA_NUM_SLOTS_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    localparam logic [3:0] FULL_COUNT = 4'(NUM_SLOTS);

    // one word in flight at a time
    `VSA_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted a word while busy")

    // a steal only happens with every slot busy and never with an ignored release
    `VSA_ASSERT_IMP(a_steal_full, aclk, aresetn, m_tvalid && m_tdata[3], !m_tdata[4] && (m_tdata[8:5] == FULL_COUNT), "steal without a full slot set")

    // busy count never exceeds the slot count
    `VSA_ASSERT_IMP(a_count_range, aclk, aresetn, m_tvalid, (NUM_SLOTS > 15) || (m_tdata[8:5] <= FULL_COUNT), "busy count out of range")

    // a stalled result holds
    `VSA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

endmodule

bind voice_slot_allocator_oldest_steal vsa_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_vsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/slot_alloc_checker.sv
// checker for the voice slot allocator: watches both stream channels, tracks busy slots
// and start order itself, and compares every result word with its predicted grant
// depends on vsa_pkg
`timescale 1ns / 1ps

module slot_alloc_checker
    import vsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);

    localparam int SLOTS = VSA_NUM_SLOTS_DEF;

    logic [SLOTS-1:0] busy_mask;
    logic [2:0]       start_order [SLOTS];
    int unsigned      order_len;
    vsa_result_t      expected_grants [$];
    vsa_result_t      want_res;
    vsa_result_t      got_res;

    task automatic drop_order_entry(input int unsigned pos);
        for (int unsigned k = pos; k + 1 < order_len; k++) begin
            start_order[k] = start_order[k + 1];
        end
        order_len--;
    endtask

    task automatic predict_grant(input logic [1:0] req, input logic [2:0] idx,
                                 output vsa_result_t res);
        int unsigned pick;
        bit          found;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        case (req)
            REQ_ALLOC: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (!found && !busy_mask[k]) begin
                        pick  = k;
                        found = 1'b1;
                    end
                end
                // all busy: evict the voice started longest ago
                if (!found && order_len > 0) begin
                    pick = start_order[0];
                    drop_order_entry(0);
                    res.stole_voice = 1'b1;
                end
                busy_mask[pick] = 1'b1;
                if (order_len < SLOTS) begin
                    start_order[order_len] = 3'(pick);
                    order_len++;
                end
                res.granted_slot = 3'(pick);
            end
            REQ_RELEASE: begin
                res.granted_slot = idx;
                if (idx < SLOTS && busy_mask[idx]) begin
                    busy_mask[idx] = 1'b0;
                    for (int unsigned k = 0; k < SLOTS; k++) begin
                        if (!found && k < order_len && start_order[k] == idx) begin
                            drop_order_entry(k);
                            found = 1'b1;
                        end
                    end
                end else begin
                    res.status = 1'b1;
                end
            end
            REQ_STOP_ALL: begin
                busy_mask = '0;
                order_len = 0;
            end
            default: ;
        endcase
        res.busy_count = 4'(order_len);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            busy_mask  = '0;
            order_len  = 0;
            fail_count = 0;
            expected_grants.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_res = vsa_result_t'(m_tdata[8:0]);
                if (expected_grants.size() == 0) begin
                    $error("result word with no request waiting: %h", m_tdata);
                    fail_count++;
                end else begin
                    want_res = expected_grants.pop_front();
                    check_field("granted_slot", want_res.granted_slot, got_res.granted_slot);
                    check_field("stole_voice", want_res.stole_voice, got_res.stole_voice);
                    check_field("status", want_res.status, got_res.status);
                    check_field("busy_count", want_res.busy_count, got_res.busy_count);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_grant(s_tuser, s_tdata[2:0], want_res);
                expected_grants.push_back(want_res);
            end
        end
        outstanding <= expected_grants.size();
    end

endmodule

// File: tb/tb_top.sv
// top of the voice slot allocator testbench: clock, reset, request stimulus,
// result-side back-pressure and the verdict
// depends on vsa_pkg, voice_slot_allocator_oldest_steal and slot_alloc_checker
`timescale 1ns / 1ps

module tb_top;
    import vsa_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;

    bit          stall_req   = 1'b0;
    bit          stall_done  = 1'b0;
    bit          burst_mode  = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned quiet_count = 0;
    int          fail_count;
    int          outstanding;

    voice_slot_allocator_oldest_steal dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    slot_alloc_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure, always ready in burst mode, plus one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= burst_mode || ($urandom_range(0, 99) >= 25);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count == QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    task automatic send_req(input logic [1:0] req, input logic [2:0] idx);
        while (!burst_mode && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'b0, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int         pick;
        int         alloc_pct;
        logic [1:0] req;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // fill every slot, then two steals of the oldest voices, then releases, an unused type and stop all
        for (int k = 0; k < 8; k++) send_req(REQ_ALLOC, 3'(k));
        send_req(REQ_ALLOC, 3'd7);
        send_req(REQ_ALLOC, 3'd0);
        send_req(REQ_RELEASE, 3'd3);
        send_req(REQ_RELEASE, 3'd3);
        send_req(REQ_UNUSED, 3'd5);
        send_req(REQ_ALLOC, 3'd6);
        send_req(REQ_RELEASE, 3'd7);
        send_req(REQ_RELEASE, 3'd0);
        send_req(REQ_ALLOC, 3'd0);
        send_req(REQ_STOP_ALL, 3'd7);
        send_req(REQ_RELEASE, 3'd5);
        send_req(REQ_STOP_ALL, 3'd0);
        send_req(REQ_ALLOC, 3'd2);
        send_req(REQ_RELEASE, 3'd0);
        drain_results();

        for (int n = 0; n < 1250; n++) begin
            if (n == 300) stall_req <= 1'b1;
            if (n == 600) burst_mode <= 1'b1;
            if (n == 750) burst_mode <= 1'b0;
            if (n == 900) drain_results();
            // phases lean toward filling up, mixing, or emptying the slots
            case ((n / 100) % 3)
                0:       alloc_pct = 70;
                1:       alloc_pct = 47;
                default: alloc_pct = 25;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) req = REQ_ALLOC;
            else if (pick < 92)   req = REQ_RELEASE;
            else if (pick < 97)   req = REQ_STOP_ALL;
            else                  req = REQ_UNUSED;
            send_req(req, 3'($urandom_range(0, 7)));
        end
        drain_results();
        repeat (20) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/vsa_pkg.sv
src/vsa_age_mem.sv
src/vsa_ctrl.sv
src/voice_slot_allocator_oldest_steal.sv
src/vsa_checker.sv
tb/slot_alloc_checker.sv
tb/tb_top.sv
